// ===== design/ttb_pkg.sv =====
// ttb_pkg: shared constants, types and helpers for the tick timer bank.
// No dependencies; used by every module of the block.
package ttb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int CMD_W       = 3;
  localparam int INDEX_W     = 4;
  localparam int MS_W        = 32;
  localparam int COUNT_W     = 31;
  localparam int SLOT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int RANGE_W     = ($clog2(NUM_TIMERS + 1) > INDEX_W) ?
                               $clog2(NUM_TIMERS + 1) : INDEX_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int IN_FIELD_W  = CMD_W + INDEX_W + MS_W;
  localparam int OUT_FIELD_W = 3 + MS_W;

  localparam logic [COUNT_W-1:0] IDLE_COUNT = 31'h7FFF_FFFF;
  localparam logic [COUNT_W-1:0] MAX_LOAD   = 31'h7FFF_FFFE;
  // ceil(2^34 / 5): (ms * DIV5_RECIP) >> 34 equals ms / 5 for every 32-bit ms
  localparam logic [MS_W-1:0]    DIV5_RECIP = 32'hCCCC_CCCD;
  localparam int                 DIV5_SHIFT = 34;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_REGISTER = 3'd1,
    CMD_SET      = 3'd2,
    CMD_CLEAR    = 3'd3,
    CMD_QUERY    = 3'd4
  } cmd_t;

  // last field (command) in the lowest bits
  typedef struct packed {
    logic [MS_W-1:0]    milliseconds;
    logic [INDEX_W-1:0] timer_index;
    logic [CMD_W-1:0]   command;
  } in_item_t;

  typedef struct packed {
    logic [MS_W-1:0] remaining_ms;
    logic            slot_registered;
    logic            slot_expired;
    logic            slot_running;
  } out_item_t;

  // addressed slot after the command has taken effect
  typedef struct packed {
    logic               expired;
    logic               enrolled;
    logic [COUNT_W-1:0] count;
  } slot_view_t;

  // milliseconds to ticks, saturated below the idle value
  function automatic logic [COUNT_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
    logic [2*MS_W-1:0]  prod;
    logic [COUNT_W-1:0] q;
    prod = {{MS_W{1'b0}}, ms} * {{MS_W{1'b0}}, DIV5_RECIP};
    q    = COUNT_W'(prod[2*MS_W-1:DIV5_SHIFT]);
    return (q < IDLE_COUNT) ? q : MAX_LOAD;
  endfunction

endpackage

// ===== design/tick_timer_bank.sv =====
// tick_timer_bank: top level of the bank of one-shot tick timers.
// Depends on ttb_pkg, ttb_slot_bank and ttb_result.
//
// A bank of NUM_TIMERS one-shot down-counting timers driven by command
// items: tick, register, set (milliseconds / 5, saturating), clear and
// query. Every item returns one result item with the addressed slot's
// running, expired and registered flags and its remaining milliseconds,
// as seen after the command has acted. Items flow through three register
// stages (input register, slot update with addressed-slot view, result
// register), so one item is taken every cycle while the pipe is not
// stalled; back-pressure on the result side stalls the whole pipe. The
// set path holds one 32x32 reciprocal multiply for the divide by five,
// which is what bounds the clock in the update stage.
module tick_timer_bank (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] command, [6:3] timer_index, [38:7] milliseconds, [39] zero
  input  logic [ttb_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] slot_running, [1] slot_expired, [2] slot_registered,
  // [34:3] remaining_ms, [39:35] zero
  output logic [ttb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  ttb_pkg::in_item_t   s0_item_r;
  logic                s0_v_r, s0_v_nxt;
  logic                s1_v_r, s1_v_nxt;
  logic                out_v_r, out_v_nxt;
  ttb_pkg::slot_view_t s1_view;
  ttb_pkg::out_item_t  res;
  ttb_pkg::out_item_t  out_item_r;
  logic                out_free, s1_ready, adv, in_acc;

  // stage ready chain, back to front
  assign out_free  = !out_v_r || out_tready;
  assign s1_ready  = !s1_v_r || out_free;
  assign in_tready = !s0_v_r || s1_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign adv       = s0_v_r && s1_ready;

  assign s0_v_nxt  = in_tready ? in_tvalid : s0_v_r;
  assign s1_v_nxt  = s1_ready  ? s0_v_r    : s1_v_r;
  assign out_v_nxt = out_free  ? s1_v_r    : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s0_v_r  <= s0_v_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s0_item_r <= ttb_pkg::in_item_t'(in_tdata[ttb_pkg::IN_FIELD_W-1:0]);
  end

  // slot state moves only when the item leaves the input register
  ttb_slot_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (s0_item_r),
    .view_r (s1_view)
  );

  ttb_result u_result (
    .view (s1_view),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (s1_v_r && out_free) out_item_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(ttb_pkg::OUT_TDATA_W - ttb_pkg::OUT_FIELD_W){1'b0}}, out_item_r};

  // running and expired are exclusive
  a_run_exp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_item_r.slot_running && out_item_r.slot_expired))
    else $error("running and expired both set");

  // expired slot reports zero time left
  a_exp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_item_r.slot_expired) |-> (out_item_r.remaining_ms == '0))
    else $error("expired slot with time left");

  // an expired view always comes from a count that reached zero
  a_view_exp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_view.expired) |-> (s1_view.count == '0))
    else $error("expired slot with non-zero count");

  // a stalled middle stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_ready) |=> (s1_v_r && $stable(s1_view)))
    else $error("stalled view lost");

endmodule

// ===== design/ttb_slot_bank.sv =====
// ttb_slot_bank: per-slot count, expired and enrolled registers with their
// command update, plus a registered view of the addressed slot. Uses ttb_pkg.
module ttb_slot_bank (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  ttb_pkg::in_item_t  item,
  output ttb_pkg::slot_view_t view_r
);

  logic [ttb_pkg::COUNT_W-1:0] count_r   [ttb_pkg::NUM_TIMERS];
  logic [ttb_pkg::COUNT_W-1:0] count_nxt [ttb_pkg::NUM_TIMERS];
  logic [ttb_pkg::NUM_TIMERS-1:0] exp_r, exp_nxt;
  logic [ttb_pkg::NUM_TIMERS-1:0] enr_r, enr_nxt;
  logic [ttb_pkg::COUNT_W-1:0] load_cnt;
  logic [ttb_pkg::RANGE_W-1:0] idx_ext;
  logic                        in_range;
  logic [ttb_pkg::SLOT_W-1:0]  sel;
  logic                        hit;
  ttb_pkg::cmd_t               cmd;
  ttb_pkg::slot_view_t         view_nxt;

  assign idx_ext  = {{(ttb_pkg::RANGE_W - ttb_pkg::INDEX_W){1'b0}}, item.timer_index};
  assign in_range = idx_ext < ttb_pkg::RANGE_W'(ttb_pkg::NUM_TIMERS);
  assign sel      = in_range ? idx_ext[ttb_pkg::SLOT_W-1:0] : '0;
  assign cmd      = ttb_pkg::cmd_t'(item.command);
  assign load_cnt = ttb_pkg::ms_to_ticks(item.milliseconds);

  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < ttb_pkg::NUM_TIMERS; s++) begin
      count_nxt[s] = count_r[s];
      exp_nxt[s]   = exp_r[s];
      enr_nxt[s]   = enr_r[s];
      hit          = in_range && (sel == ttb_pkg::SLOT_W'(s));
      case (cmd)
        ttb_pkg::CMD_TICK: begin
          if (enr_r[s] && !exp_r[s] && (count_r[s] != ttb_pkg::IDLE_COUNT)) begin
            if (count_r[s] == '0) exp_nxt[s] = 1'b1;
            else                  count_nxt[s] = count_r[s] - 1'b1;
          end
        end
        ttb_pkg::CMD_REGISTER: begin
          // already enrolled: left as it is
          if (hit && !enr_r[s]) begin
            enr_nxt[s]   = 1'b1;
            count_nxt[s] = ttb_pkg::IDLE_COUNT;
            exp_nxt[s]   = 1'b0;
          end
        end
        ttb_pkg::CMD_SET: begin
          if (hit) begin
            count_nxt[s] = load_cnt;
            exp_nxt[s]   = 1'b0;
          end
        end
        ttb_pkg::CMD_CLEAR: begin
          if (hit) begin
            count_nxt[s] = ttb_pkg::IDLE_COUNT;
            exp_nxt[s]   = 1'b0;
          end
        end
        default: ; // query and unknown codes change nothing
      endcase
    end
  end

  // out-of-range index reads as an idle, unenrolled slot
  always_comb begin
    if (in_range) begin
      view_nxt.expired  = exp_nxt[sel];
      view_nxt.enrolled = enr_nxt[sel];
      view_nxt.count    = count_nxt[sel];
    end else begin
      view_nxt.expired  = 1'b0;
      view_nxt.enrolled = 1'b0;
      view_nxt.count    = ttb_pkg::IDLE_COUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ttb_pkg::NUM_TIMERS; s++) count_r[s] <= ttb_pkg::IDLE_COUNT;
      exp_r <= '0;
      enr_r <= '0;
    end else if (adv) begin
      for (int s = 0; s < ttb_pkg::NUM_TIMERS; s++) count_r[s] <= count_nxt[s];
      exp_r <= exp_nxt;
      enr_r <= enr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) view_r <= view_nxt;
  end

endmodule

// ===== design/ttb_result.sv =====
// ttb_result: turns a slot view into the result item (flags and remaining
// milliseconds). Uses ttb_pkg.
module ttb_result (
  input  ttb_pkg::slot_view_t view,
  output ttb_pkg::out_item_t  res
);

  logic                        running;
  logic [ttb_pkg::COUNT_W+1:0] times5;

  assign running = !view.expired && (view.count != ttb_pkg::IDLE_COUNT);
  // count * 5 as shift and add, kept to 32 bits
  assign times5  = {view.count, 2'b00} + {2'b00, view.count};

  always_comb begin
    res.slot_running    = running;
    res.slot_expired    = view.expired;
    res.slot_registered = view.enrolled;
    if (view.expired)  res.remaining_ms = '0;
    else if (!running) res.remaining_ms = '1;
    else               res.remaining_ms = times5[ttb_pkg::MS_W-1:0];
  end

endmodule
